[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define PST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PST_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`PST_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[src/pst_pkg.sv]
// Types, constants and helper functions of the Phong specular term pipeline.
package pst_pkg;

	localparam int VECTOR_BITS = 16;
	localparam int RED_SHIFT = (VECTOR_BITS > 16) ? VECTOR_BITS - 16 : 0;

	// Delay from request to result.
	localparam int PST_LATENCY = 96;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAT_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAT_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAT_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 3'd3;
	localparam logic [15:0] SHININESS_RESET = 16'd256;

	typedef logic signed [15:0] vec16_t;

	typedef struct packed {
		logic signed [VECTOR_BITS-1:0] light_dir_x;
		logic signed [VECTOR_BITS-1:0] light_dir_y;
		logic signed [VECTOR_BITS-1:0] light_dir_z;
		logic signed [VECTOR_BITS-1:0] normal_x;
		logic signed [VECTOR_BITS-1:0] normal_y;
		logic signed [VECTOR_BITS-1:0] normal_z;
		logic signed [VECTOR_BITS-1:0] view_dir_x;
		logic signed [VECTOR_BITS-1:0] view_dir_y;
		logic signed [VECTOR_BITS-1:0] view_dir_z;
		logic [15:0] light_spec_red;
		logic [15:0] light_spec_green;
		logic [15:0] light_spec_blue;
	} pst_in_t;

	typedef struct packed {
		logic [15:0] spec_red;
		logic [15:0] spec_green;
		logic [15:0] spec_blue;
	} pst_out_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} pst_color_t;

	// Geometry result: numerator p and |R|^2 |V|^2.
	typedef struct packed {
		logic        zero;
		logic [31:0] p;
		logic [63:0] rv2;
		pst_color_t  color;
	} pst_geo_t;

	// Cosine, Q1.16.
	typedef struct packed {
		logic        zero;
		logic [16:0] c;
		pst_color_t  color;
	} pst_cos_t;

	// Power term, Q1.16.
	typedef struct packed {
		logic        zero;
		logic [16:0] pw;
		pst_color_t  color;
	} pst_pow_t;

	// Sign-extend and reduce a vector component to 16 bits (floor).
	function automatic vec16_t vec_in(input logic signed [VECTOR_BITS-1:0] x);
		logic signed [VECTOR_BITS+15:0] w;
		w = {{16{x[VECTOR_BITS-1]}}, x};
		w = w >>> RED_SHIFT;
		return w[15:0];
	endfunction

	// Floor square root, elaboration use only.
	function automatic logic [63:0] isqrt_const(input logic [63:0] x);
		logic [63:0] xv;
		logic [63:0] rv;
		logic [63:0] bv;
		xv = x;
		rv = '0;
		bv = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (xv >= rv + bv) begin
				xv = xv - (rv + bv);
				rv = (rv >> 1) + bv;
			end else begin
				rv = rv >> 1;
			end
			bv = bv >> 2;
		end
		return rv;
	endfunction

	// 2^(2^-(i+1)) in Q2.30, from repeated square roots of 2.
	function automatic logic [31:0] exp_root(input int i);
		logic [63:0] rt;
		rt = isqrt_const(64'h2000_0000_0000_0000);
		for (int j = 1; j <= i; j++) begin
			rt = isqrt_const(rt << 30);
		end
		return rt[31:0];
	endfunction

endpackage

[src/phong_specular_term.sv]
// Top level of the Phong specular term: registers, pipeline and color stages.
//
//  channel  | ports                              | transfer
//  ---------+------------------------------------+-------------------------------
//  request  | start, busy, item                  | start && !busy at clk rise
//  result   | done, result                       | done high for one cycle
//  config   | cfg_we, cfg_index, cfg_data        | cfg_we at clk rise
//
// One request per cycle; each request gives one result.
// Pipeline order: geometry, square root, divide, power, color.
// busy stays low: the pipeline never stops, results cannot be held off.
// arst_n clears all valid bits and the config registers; no clearing pass.
module phong_specular_term #(
	parameter int COLOR_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pst_pkg::pst_in_t               item,
	output logic                           done,
	output pst_pkg::pst_out_t              result,
	input  logic                           cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);
	import pst_pkg::*;

	localparam int SH = COLOR_FRAC_BITS + 16;
	localparam logic [15:0] CAP = (COLOR_FRAC_BITS >= 16) ? 16'hFFFF
		: 16'(1 << COLOR_FRAC_BITS);

	logic [15:0] mat_red_q, mat_green_q, mat_blue_q, shin_q;

	logic     geo_v, cos_v, pow_v;
	pst_geo_t geo;
	pst_cos_t cos_w;
	pst_pow_t pow_w;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] lm_s1 [3];
	logic [16:0] pw_s1;
	logic        zero_s1, zero_s2;
	logic [48:0] prod_s2 [3];
	logic [49:0] rnd_c [3];
	logic [15:0] ch_c [3];
	pst_out_t    res_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_red_q   <= '0;
			mat_green_q <= '0;
			mat_blue_q  <= '0;
			shin_q      <= SHININESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAT_RED:   mat_red_q   <= cfg_data;
				CFG_MAT_GREEN: mat_green_q <= cfg_data;
				CFG_MAT_BLUE:  mat_blue_q  <= cfg_data;
				CFG_SHININESS: shin_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	pst_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.item     (item),
		.out_valid(geo_v),
		.geo      (geo)
	);

	pst_cosine u_cosine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (geo_v),
		.geo      (geo),
		.out_valid(cos_v),
		.cos_o    (cos_w)
	);

	pst_pow u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cos_v),
		.cos_i    (cos_w),
		.shininess(shin_q),
		.out_valid(pow_v),
		.pow_o    (pow_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= pow_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// light * material, then * pow
	always_ff @(posedge clk) begin
		lm_s1[0] <= pow_w.color.red   * mat_red_q;
		lm_s1[1] <= pow_w.color.green * mat_green_q;
		lm_s1[2] <= pow_w.color.blue  * mat_blue_q;
		pw_s1    <= pow_w.pw;
		zero_s1  <= pow_w.zero;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= lm_s1[i] * pw_s1;
		end
		zero_s2 <= zero_s1;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = ({1'b0, prod_s2[i]} + (50'd1 << (SH - 1))) >> SH;
			ch_c[i]  = zero_s2 ? 16'd0
				: ((rnd_c[i] > 50'(CAP)) ? CAP : rnd_c[i][15:0]);
		end
	end

	always_ff @(posedge clk) begin
		res_s3.spec_red   <= ch_c[0];
		res_s3.spec_green <= ch_c[1];
		res_s3.spec_blue  <= ch_c[2];
	end

	assign done   = v_s3;
	assign result = res_s3;

endmodule

[src/pst_geom.sv]
// Vector stages: reflection, exponent scaling, dot products and magnitude product.
module pst_geom (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pst_pkg::pst_in_t  item,
	output logic              out_valid,
	output pst_pkg::pst_geo_t geo
);
	import pst_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	vec16_t l_s1 [3];
	vec16_t n_s1 [3];
	vec16_t vd_s1 [3];
	pst_color_t color_s1;

	logic signed [31:0] ln_c [3];
	logic signed [31:0] nn_c [3];
	logic signed [31:0] vv_c [3];
	logic signed [33:0] d_c;
	logic [31:0] n2_c, v2_c;

	logic signed [33:0] d_s2;
	logic [31:0] n2_s2, v2_s2;
	logic vz_s2;
	vec16_t l_s2 [3];
	vec16_t n_s2 [3];
	vec16_t vd_s2 [3];
	pst_color_t color_s2;

	logic signed [49:0] a_s3 [3];
	logic signed [48:0] b_s3 [3];
	logic [31:0] v2_s3;
	logic vz_s3;
	vec16_t vd_s3 [3];
	pst_color_t color_s3;

	logic signed [50:0] r_c [3];
	logic signed [50:0] r_s4 [3];
	logic [31:0] v2_s4;
	logic vz_s4;
	vec16_t vd_s4 [3];
	pst_color_t color_s4;

	logic [50:0] orv_c;
	logic [5:0] bl_c, sh_c;
	logic signed [50:0] r_s5 [3];
	logic [5:0] sh_s5;
	logic rz_s5;
	logic [31:0] v2_s5;
	logic vz_s5;
	vec16_t vd_s5 [3];
	pst_color_t color_s5;

	logic signed [50:0] rsh_c [3];
	vec16_t rs_s6 [3];
	logic zero_s6;
	logic [31:0] v2_s6;
	vec16_t vd_s6 [3];
	pst_color_t color_s6;

	logic signed [31:0] rv_c [3];
	logic signed [31:0] rr_c [3];
	logic signed [33:0] p_c;
	logic [31:0] r2_c;
	logic signed [33:0] p_s7;
	logic [31:0] r2_s7, v2_s7;
	logic zero_s7;
	pst_color_t color_s7;

	pst_geo_t geo_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: reduce to 16 bits
	always_ff @(posedge clk) begin
		l_s1[0]  <= vec_in(item.light_dir_x);
		l_s1[1]  <= vec_in(item.light_dir_y);
		l_s1[2]  <= vec_in(item.light_dir_z);
		n_s1[0]  <= vec_in(item.normal_x);
		n_s1[1]  <= vec_in(item.normal_y);
		n_s1[2]  <= vec_in(item.normal_z);
		vd_s1[0] <= vec_in(item.view_dir_x);
		vd_s1[1] <= vec_in(item.view_dir_y);
		vd_s1[2] <= vec_in(item.view_dir_z);
		color_s1 <= '{red: item.light_spec_red, green: item.light_spec_green,
			blue: item.light_spec_blue};
	end

	// stage 2: L.N, |N|^2, |V|^2
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ln_c[i] = l_s1[i] * n_s1[i];
			nn_c[i] = n_s1[i] * n_s1[i];
			vv_c[i] = vd_s1[i] * vd_s1[i];
		end
		d_c  = 34'(ln_c[0]) + 34'(ln_c[1]) + 34'(ln_c[2]);
		n2_c = $unsigned(nn_c[0]) + $unsigned(nn_c[1]) + $unsigned(nn_c[2]);
		v2_c = $unsigned(vv_c[0]) + $unsigned(vv_c[1]) + $unsigned(vv_c[2]);
	end

	always_ff @(posedge clk) begin
		d_s2     <= d_c;
		n2_s2    <= n2_c;
		v2_s2    <= v2_c;
		vz_s2    <= (vd_s1[0] == '0) && (vd_s1[1] == '0) && (vd_s1[2] == '0);
		l_s2     <= l_s1;
		n_s2     <= n_s1;
		vd_s2    <= vd_s1;
		color_s2 <= color_s1;
	end

	// stage 3: d*N and |N|^2*L
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s3[i] <= d_s2 * n_s2[i];
			b_s3[i] <= $signed({1'b0, n2_s2}) * l_s2[i];
		end
		v2_s3    <= v2_s2;
		vz_s3    <= vz_s2;
		vd_s3    <= vd_s2;
		color_s3 <= color_s2;
	end

	// stage 4: R = 2dN - |N|^2 L, exact
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i] = $signed({a_s3[i], 1'b0}) - 51'(b_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		r_s4     <= r_c;
		v2_s4    <= v2_s3;
		vz_s4    <= vz_s3;
		vd_s4    <= vd_s3;
		color_s4 <= color_s3;
	end

	// stage 5: shift that brings all of R into 16 bits
	always_comb begin
		orv_c = '0;
		for (int i = 0; i < 3; i++) begin
			orv_c = orv_c | (r_s4[i][50] ? ~r_s4[i] : r_s4[i]);
		end
		bl_c = '0;
		for (int j = 0; j < 51; j++) begin
			if (orv_c[j]) begin
				bl_c = 6'(j + 1);
			end
		end
		sh_c = (bl_c > 6'd15) ? bl_c - 6'd15 : 6'd0;
	end

	always_ff @(posedge clk) begin
		r_s5     <= r_s4;
		sh_s5    <= sh_c;
		rz_s5    <= (r_s4[0] == '0) && (r_s4[1] == '0) && (r_s4[2] == '0);
		v2_s5    <= v2_s4;
		vz_s5    <= vz_s4;
		vd_s5    <= vd_s4;
		color_s5 <= color_s4;
	end

	// stage 6: scale R
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsh_c[i] = r_s5[i] >>> sh_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rs_s6[i] <= rsh_c[i][15:0];
		end
		zero_s6  <= rz_s5 | vz_s5;
		v2_s6    <= v2_s5;
		vd_s6    <= vd_s5;
		color_s6 <= color_s5;
	end

	// stage 7: p = -(R.V), |R|^2
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rv_c[i] = rs_s6[i] * vd_s6[i];
			rr_c[i] = rs_s6[i] * rs_s6[i];
		end
		p_c  = -(34'(rv_c[0]) + 34'(rv_c[1]) + 34'(rv_c[2]));
		r2_c = $unsigned(rr_c[0]) + $unsigned(rr_c[1]) + $unsigned(rr_c[2]);
	end

	always_ff @(posedge clk) begin
		p_s7     <= p_c;
		r2_s7    <= r2_c;
		v2_s7    <= v2_s6;
		zero_s7  <= zero_s6;
		color_s7 <= color_s6;
	end

	// stage 8: |R|^2 |V|^2
	always_ff @(posedge clk) begin
		geo_s8.zero  <= zero_s7 | (p_s7 <= 34'sd0);
		geo_s8.p     <= p_s7[31:0];
		geo_s8.rv2   <= r2_s7 * v2_s7;
		geo_s8.color <= color_s7;
	end

	assign out_valid = v_s8;
	assign geo       = geo_s8;

endmodule

[src/pst_cosine.sv]
// Cosine: pipelined square root of |R|^2|V|^2, then pipelined divide of p by it.
module pst_cosine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pst_pkg::pst_geo_t geo,
	output logic              out_valid,
	output pst_pkg::pst_cos_t cos_o
);
	import pst_pkg::*;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 17;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
		logic [63:0] x;
		logic [31:0] p;
		logic        zero;
		pst_color_t  color;
	} sq_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [16:0] q;
		logic [31:0] m;
		logic        zero;
		pst_color_t  color;
	} dv_t;

	sq_t  sq_cur [SQ_STEPS];
	logic sqv_cur [SQ_STEPS];
	sq_t  sq_s [SQ_STEPS];
	logic sqv_s [SQ_STEPS];

	dv_t  dv_cur [DIV_STEPS];
	logic dvv_cur [DIV_STEPS];
	dv_t  dv_s [DIV_STEPS];
	logic dvv_s [DIV_STEPS];

	assign sq_cur[0]  = '{rem: '0, root: '0, x: geo.rv2, p: geo.p, zero: geo.zero,
		color: geo.color};
	assign sqv_cur[0] = in_valid;

	// one root bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [34:0] rem_n, trial;

		if (k > 0) begin : g_link
			assign sq_cur[k]  = sq_s[k-1];
			assign sqv_cur[k] = sqv_s[k-1];
		end

		always_comb begin
			rem_n = {sq_cur[k].rem[32:0], sq_cur[k].x[63:62]};
			trial = {1'b0, sq_cur[k].root, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k] <= 1'b0;
			end else begin
				sqv_s[k] <= sqv_cur[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_s[k].x     <= {sq_cur[k].x[61:0], 2'b00};
			sq_s[k].p     <= sq_cur[k].p;
			sq_s[k].zero  <= sq_cur[k].zero;
			sq_s[k].color <= sq_cur[k].color;
			if (rem_n >= trial) begin
				sq_s[k].rem  <= rem_n - trial;
				sq_s[k].root <= {sq_cur[k].root[30:0], 1'b1};
			end else begin
				sq_s[k].rem  <= rem_n;
				sq_s[k].root <= {sq_cur[k].root[30:0], 1'b0};
			end
		end
	end

	// p never exceeds the root, so the quotient fits 17 bits
	assign dv_cur[0] = '{rem: {1'b0, sq_s[SQ_STEPS-1].p}, q: '0,
		m: sq_s[SQ_STEPS-1].root,
		zero: sq_s[SQ_STEPS-1].zero | (sq_s[SQ_STEPS-1].root == '0),
		color: sq_s[SQ_STEPS-1].color};
	assign dvv_cur[0] = sqv_s[SQ_STEPS-1];

	// one quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [32:0] rt;
		logic ge;

		if (j > 0) begin : g_link
			assign dv_cur[j]  = dv_s[j-1];
			assign dvv_cur[j] = dvv_s[j-1];
		end

		always_comb begin
			rt = (j == 0) ? dv_cur[j].rem : {dv_cur[j].rem[31:0], 1'b0};
			ge = rt >= {1'b0, dv_cur[j].m};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[j] <= 1'b0;
			end else begin
				dvv_s[j] <= dvv_cur[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_s[j].rem   <= ge ? rt - {1'b0, dv_cur[j].m} : rt;
			dv_s[j].q     <= {dv_cur[j].q[15:0], ge};
			dv_s[j].m     <= dv_cur[j].m;
			dv_s[j].zero  <= dv_cur[j].zero;
			dv_s[j].color <= dv_cur[j].color;
		end
	end

	assign out_valid   = dvv_s[DIV_STEPS-1];
	assign cos_o.zero  = dv_s[DIV_STEPS-1].zero;
	assign cos_o.c     = (dv_s[DIV_STEPS-1].q > 17'h10000) ? 17'h10000
		: dv_s[DIV_STEPS-1].q;
	assign cos_o.color = dv_s[DIV_STEPS-1].color;

endmodule

[src/pst_pow.sv]
// Power c^e: log2 by repeated squaring, scale by exponent, exp2 by root products.
module pst_pow (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pst_pkg::pst_cos_t cos_i,
	input  logic [15:0]       shininess,
	output logic              out_valid,
	output pst_pkg::pst_pow_t pow_o
);
	import pst_pkg::*;

	localparam int LOG_STEPS = 16;
	localparam int EXP_STEPS = 16;

	typedef struct packed {
		logic [30:0] y;
		logic [15:0] frac;
		logic [4:0]  b;
		logic        czero;
		logic        zero;
		pst_color_t  color;
	} lg_t;

	typedef struct packed {
		logic [31:0] acc;
		logic [15:0] g;
		logic [4:0]  k;
		logic        one;
		logic        pzero;
		logic        zero;
		pst_color_t  color;
	} ex_t;

	lg_t  lg_s [LOG_STEPS+1];
	logic lgv_s [LOG_STEPS+1];
	ex_t  ex_s [EXP_STEPS+1];
	logic exv_s [EXP_STEPS+1];

	logic [4:0] bl_c, b_c;

	logic [20:0] t_s;
	logic        czero_t, zero_t, vt_s;
	pst_color_t  color_t;

	logic [36:0] te_c;
	logic [28:0] u_c;
	logic [12:0] k_c;
	logic [15:0] f_c;

	logic [5:0]  sh_c;
	logic [33:0] sum_c, pw_c;
	pst_pow_t    pow_q;
	logic        vo_q;

	// leading one of c
	always_comb begin
		bl_c = '0;
		for (int j = 0; j < 17; j++) begin
			if (cos_i.c[j]) begin
				bl_c = 5'(j + 1);
			end
		end
		b_c = bl_c - 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lgv_s[0] <= 1'b0;
		end else begin
			lgv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lg_s[0].y     <= 31'({14'd0, cos_i.c} << (5'd30 - b_c));
		lg_s[0].frac  <= '0;
		lg_s[0].b     <= b_c;
		lg_s[0].czero <= (cos_i.c == '0);
		lg_s[0].zero  <= cos_i.zero;
		lg_s[0].color <= cos_i.color;
	end

	// one fraction bit of log2 per stage
	for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
		logic [61:0] sq;

		assign sq = lg_s[i-1].y * lg_s[i-1].y;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lgv_s[i] <= 1'b0;
			end else begin
				lgv_s[i] <= lgv_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			lg_s[i].y     <= sq[61] ? sq[61:31] : sq[60:30];
			lg_s[i].frac  <= {lg_s[i-1].frac[14:0], sq[61]};
			lg_s[i].b     <= lg_s[i-1].b;
			lg_s[i].czero <= lg_s[i-1].czero;
			lg_s[i].zero  <= lg_s[i-1].zero;
			lg_s[i].color <= lg_s[i-1].color;
		end
	end

	// t = -log2(c) in Q.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vt_s <= 1'b0;
		end else begin
			vt_s <= lgv_s[LOG_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		t_s     <= 21'({5'd16 - lg_s[LOG_STEPS].b, 16'h0000})
			- 21'(lg_s[LOG_STEPS].frac);
		czero_t <= lg_s[LOG_STEPS].czero;
		zero_t  <= lg_s[LOG_STEPS].zero;
		color_t <= lg_s[LOG_STEPS].color;
	end

	// u = t * e, rounded to Q.16
	always_comb begin
		te_c = 37'(t_s) * 37'(shininess) + 37'd128;
		u_c  = te_c[36:8];
		k_c  = u_c[28:16];
		f_c  = u_c[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exv_s[0] <= 1'b0;
		end else begin
			exv_s[0] <= vt_s;
		end
	end

	always_ff @(posedge clk) begin
		ex_s[0].acc   <= (f_c == '0) ? 32'h8000_0000 : 32'h4000_0000;
		ex_s[0].g     <= 16'(17'h10000 - {1'b0, f_c});
		ex_s[0].k     <= k_c[4:0];
		ex_s[0].one   <= (shininess == '0);
		ex_s[0].pzero <= czero_t | (k_c >= 13'd18);
		ex_s[0].zero  <= zero_t;
		ex_s[0].color <= color_t;
	end

	// 2^(1-frac) as a product of roots, one per stage
	for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
		localparam logic [31:0] ROOT = exp_root(i);
		logic [63:0] mul;

		assign mul = ex_s[i].acc * ROOT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				exv_s[i+1] <= 1'b0;
			end else begin
				exv_s[i+1] <= exv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			ex_s[i+1].acc   <= ex_s[i].g[15-i] ? mul[61:30] : ex_s[i].acc;
			ex_s[i+1].g     <= ex_s[i].g;
			ex_s[i+1].k     <= ex_s[i].k;
			ex_s[i+1].one   <= ex_s[i].one;
			ex_s[i+1].pzero <= ex_s[i].pzero;
			ex_s[i+1].zero  <= ex_s[i].zero;
			ex_s[i+1].color <= ex_s[i].color;
		end
	end

	// scale by 2^-(k+1) and round to Q1.16
	always_comb begin
		sh_c  = 6'd15 + {1'b0, ex_s[EXP_STEPS].k};
		sum_c = {2'b00, ex_s[EXP_STEPS].acc} + (34'd1 << (sh_c - 6'd1));
		pw_c  = sum_c >> sh_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else begin
			vo_q <= exv_s[EXP_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ex_s[EXP_STEPS].one) begin
			pow_q.pw <= 17'h10000;
		end else if (ex_s[EXP_STEPS].pzero) begin
			pow_q.pw <= '0;
		end else begin
			pow_q.pw <= pw_c[16:0];
		end
		pow_q.zero  <= ex_s[EXP_STEPS].zero;
		pow_q.color <= ex_s[EXP_STEPS].color;
	end

	assign out_valid = vo_q;
	assign pow_o     = pow_q;

endmodule

[src/pst_checker.sv]
// Port-level checks of the specular term pipeline, bound to the top level.
`include "assert_macros.svh"

module pst_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import pst_pkg::*;

	// pipeline never refuses a request
	`PST_ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "busy raised")

	// every accepted request gives a result on done
	`PST_ASSERT(a_req_to_done, clk, arst_n, (start && !busy) |-> ##PST_LATENCY done, "result missing")

	// no result without a matching earlier request
	`PST_ASSERT(a_done_from_req, clk, arst_n, done |-> $past(start && !busy, PST_LATENCY), "result without request")

endmodule

bind phong_specular_term pst_checker u_pst_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
